// ===== hw/rtl/tqpr_pkg.sv =====
// tqpr_pkg: shared types and codes for the two-queue page replacement frame table
// no dependencies
`default_nettype none
package tqpr_pkg;
  localparam int unsigned PAGE_W   = 64;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_FREE      = 3'd1,
    ST_EVICT     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_UNFIX = 3'd4
  } status_t;

  localparam logic ACT_FIX   = 1'b0;
  localparam logic ACT_UNFIX = 1'b1;

  // per-frame update command broadcast to every cell
  typedef struct packed {
    logic        hit_fix;     // move hit frame to lru head
    logic        unfix;       // lower pin of target
    logic        set_dirty;
    logic        load;        // write new page into target
    logic        load_evict;  // load replaces a resident page
    logic        load_lru;    // new page joins lru queue
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tqpr_cell.sv =====
// tqpr_cell: one frame of the table (tag, flags, pin count, queue rank)
// depends on tqpr_pkg
`default_nettype none
module tqpr_cell #(
  parameter int unsigned PIN_BITS = 8,
  parameter int unsigned RANK_W   = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        is_target,
  input  wire logic                        cmd_en,
  input  wire tqpr_pkg::cell_cmd_t         cmd,
  input  wire logic [tqpr_pkg::PAGE_W-1:0] new_tag,
  input  wire logic                        tgt_in_lru,
  input  wire logic [RANK_W-1:0]           tgt_rank,
  input  wire logic                        tgt_valid,
  output logic [tqpr_pkg::PAGE_W-1:0]      tag,
  output logic                             valid,
  output logic                             in_lru,
  output logic [PIN_BITS-1:0]              pin,
  output logic                             dirty,
  output logic [RANK_W-1:0]                rank
);
  logic [tqpr_pkg::PAGE_W-1:0] tag_r;
  logic valid_r, in_lru_r, dirty_r;
  logic [PIN_BITS-1:0] pin_r;
  logic [RANK_W-1:0] rank_r;
  logic [RANK_W-1:0] rank_rm;
  logic dec, inc;
  logic push_lru;

  assign tag = tag_r;
  assign valid = valid_r;
  assign in_lru = in_lru_r;
  assign pin = pin_r;
  assign dirty = dirty_r;
  assign rank = rank_r;

  always_comb begin
    push_lru = cmd.hit_fix | cmd.load_lru;
    // removal of target from its queue (hit or eviction)
    dec = valid_r && !is_target && tgt_valid && (cmd.hit_fix || cmd.load_evict)
          && (in_lru_r == tgt_in_lru) && (rank_r > tgt_rank);
    rank_rm = dec ? rank_r - 1'b1 : rank_r;
    inc = valid_r && !is_target && (cmd.hit_fix || cmd.load) && (in_lru_r == push_lru);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      in_lru_r <= 1'b0;
      dirty_r <= 1'b0;
      pin_r <= '0;
      rank_r <= '0;
    end else if (cmd_en) begin
      rank_r <= inc ? rank_rm + 1'b1 : rank_rm;
      if (is_target) begin
        if (cmd.unfix) begin
          pin_r <= pin_r - 1'b1;
          if (cmd.set_dirty) dirty_r <= 1'b1;
        end else if (cmd.hit_fix) begin
          if (pin_r != {PIN_BITS{1'b1}}) pin_r <= pin_r + 1'b1;
          in_lru_r <= 1'b1;
          rank_r <= '0;
        end else if (cmd.load) begin
          valid_r <= 1'b1;
          pin_r <= {{(PIN_BITS-1){1'b0}}, 1'b1};
          dirty_r <= 1'b0;
          in_lru_r <= cmd.load_lru;
          rank_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_en && is_target && cmd.load) tag_r <= new_tag;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/two_queue_page_replacement.sv =====
// two_queue_page_replacement: top level, row of frame cells plus scan sequencer
// depends on tqpr_pkg and tqpr_cell
//
// channel | dir | payload
// in_     | in  | tdata: action[0], page_id[64:1], mark_dirty[65], pad to 72
// out_    | out | tdata: status, frame, load_request, evict_valid, evict_page_id,
//         |     |        evict_writeback, resident_count (79 bits, pad to 88)
// cfg_    | in  | apb, frames_in_use at address 0
//
// a request is taken only in idle; the scan then visits one frame per cycle for
// lookup, first free frame and both victim searches, and the apply state then
// broadcasts the update to all cells
// out_tvalid is high in the output state that follows scan and apply; the block
// returns to idle and takes the next request only once out_tready is seen high
// there, so the result waits in the output state while out_tready stays low
// reset is synchronous; no clearing pass, all frame flags are flops
// one request in flight; a waiting result holds out_tvalid and blocks input
`default_nettype none
module two_queue_page_replacement #(
  parameter int unsigned FRAMES   = 16,
  parameter int unsigned PIN_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // action, page_id, mark_dirty, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // status, frame, load_request, evict_valid,
                                       // evict_page_id, evict_writeback, resident_count
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
  localparam int unsigned RANK_W = IDX_W;

  typedef enum logic [1:0] { S_IDLE, S_SCAN, S_APPLY, S_OUT } state_t;

  state_t state_r;
  logic [4:0] fiu_r;
  logic [IDX_W-1:0] ptr_r;
  logic act_r, mdirty_r;
  logic [tqpr_pkg::PAGE_W-1:0] pid_r;

  // scan results
  logic hit_r, free_r, fo_r, lo_r;
  logic [IDX_W-1:0] hit_f_r, free_f_r, fo_f_r, lo_f_r;
  logic [RANK_W-1:0] fo_k_r, lo_k_r;
  logic [CNT_W-1:0] res_r;

  // request outcome
  logic [2:0] o_status_r;
  logic [3:0] o_frame_r;
  logic o_load_r, o_ev_r, o_wb_r;
  logic [63:0] o_evid_r;

  logic [IDX_W-1:0] tgt;
  logic cmd_en;
  tqpr_pkg::cell_cmd_t cmd;

  logic [tqpr_pkg::PAGE_W-1:0] c_tag [FRAMES];
  logic [FRAMES-1:0] c_valid, c_lru, c_dirty;
  logic [PIN_BITS-1:0] c_pin [FRAMES];
  logic [RANK_W-1:0] c_rank [FRAMES];

  // frame-limit clamp: 0 acts as 1, above FRAMES acts as FRAMES
  logic [CNT_W:0] limit;
  always_comb begin
    if (fiu_r == 5'd0) limit = (CNT_W+1)'(1);
    else if ({27'd0, fiu_r} > 32'(FRAMES)) limit = (CNT_W+1)'(FRAMES);
    else limit = (CNT_W+1)'(fiu_r);
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {27'd0, fiu_r} : 32'd0;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {9'd0, 5'(res_r), o_wb_r, o_evid_r,
                      o_ev_r, o_load_r, o_frame_r, o_status_r};

  // decision made at the end of the scan
  logic cur_valid, cur_lru, cur_pin0;
  logic use_free, use_fifo, use_lru;
  always_comb begin
    cur_valid = c_valid[ptr_r];
    cur_lru   = c_lru[ptr_r];
    cur_pin0  = (c_pin[ptr_r] == '0);
    use_free  = free_r && ({1'b0, res_r} < limit);
    use_fifo  = !use_free && fo_r;
    use_lru   = !use_free && !fo_r && lo_r;
    cmd = '0;
    tgt = hit_f_r;
    if (act_r == tqpr_pkg::ACT_UNFIX) begin
      cmd.unfix = hit_r && (c_pin[hit_f_r] != '0);
      cmd.set_dirty = mdirty_r;
    end else if (hit_r) begin
      cmd.hit_fix = 1'b1;
    end else begin
      cmd.load = use_free || use_fifo || use_lru;
      cmd.load_evict = use_fifo || use_lru;
      cmd.load_lru = use_lru;
      tgt = use_free ? free_f_r : (use_fifo ? fo_f_r : lo_f_r);
    end
    cmd_en = (state_r == S_APPLY);
  end

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      tqpr_cell #(.PIN_BITS(PIN_BITS), .RANK_W(RANK_W)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .is_target(tgt == IDX_W'(g)),
        .cmd_en(cmd_en), .cmd(cmd), .new_tag(pid_r),
        .tgt_in_lru(c_lru[tgt]), .tgt_rank(c_rank[tgt]), .tgt_valid(c_valid[tgt]),
        .tag(c_tag[g]), .valid(c_valid[g]), .in_lru(c_lru[g]),
        .pin(c_pin[g]), .dirty(c_dirty[g]), .rank(c_rank[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fiu_r <= 5'd16;
      res_r <= '0;
      ptr_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        fiu_r <= cfg_pwdata[4:0];
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            act_r <= in_tdata[0];
            pid_r <= in_tdata[64:1];
            mdirty_r <= in_tdata[65];
            hit_r <= 1'b0; free_r <= 1'b0; fo_r <= 1'b0; lo_r <= 1'b0;
            ptr_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one frame per cycle: lookup, first free, oldest unpinned per queue
          if (cur_valid && c_tag[ptr_r] == pid_r && !hit_r) begin
            hit_r <= 1'b1; hit_f_r <= ptr_r;
          end
          if (!cur_valid && !free_r) begin
            free_r <= 1'b1; free_f_r <= ptr_r;
          end
          if (cur_valid && !cur_lru && cur_pin0 && (!fo_r || c_rank[ptr_r] > fo_k_r)) begin
            fo_r <= 1'b1; fo_f_r <= ptr_r; fo_k_r <= c_rank[ptr_r];
          end
          if (cur_valid && cur_lru && cur_pin0 && (!lo_r || c_rank[ptr_r] > lo_k_r)) begin
            lo_r <= 1'b1; lo_f_r <= ptr_r; lo_k_r <= c_rank[ptr_r];
          end
          if (ptr_r == IDX_W'(FRAMES-1)) state_r <= S_APPLY;
          else ptr_r <= ptr_r + 1'b1;
        end
        S_APPLY: begin
          o_load_r <= cmd.load;
          o_ev_r <= cmd.load_evict;
          o_evid_r <= cmd.load_evict ? c_tag[tgt] : 64'd0;
          o_wb_r <= cmd.load_evict && c_dirty[tgt];
          o_frame_r <= 4'(tgt);
          if (act_r == tqpr_pkg::ACT_UNFIX) begin
            o_status_r <= cmd.unfix ? tqpr_pkg::ST_HIT : tqpr_pkg::ST_BAD_UNFIX;
            if (!cmd.unfix) o_frame_r <= 4'd0;
          end else if (hit_r) begin
            o_status_r <= tqpr_pkg::ST_HIT;
          end else if (use_free) begin
            o_status_r <= tqpr_pkg::ST_FREE;
            res_r <= res_r + 1'b1;
          end else if (cmd.load) begin
            o_status_r <= tqpr_pkg::ST_EVICT;
          end else begin
            o_status_r <= tqpr_pkg::ST_FULL;
            o_frame_r <= 4'd0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tqpr_checker.sv =====
// tqpr_checker: port-level assertions for two_queue_page_replacement
// depends on tqpr_pkg; bound to the top level below
`default_nettype none
module tqpr_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  // no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("excl");
  // an accepted request closes the input for the next cycle
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("one");
  // no eviction data without eviction
  a_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[72:9] == 64'd0 && !out_tdata[73])
    else $error("ev");
  // load only on free or evict status
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[2:0] == tqpr_pkg::ST_FREE ||
                                   out_tdata[2:0] == tqpr_pkg::ST_EVICT)
    else $error("load");
endmodule

bind two_queue_page_replacement tqpr_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// ===== tb/tqpr_checker.sv =====
// tqpr_checker: watches the request, result and register channels of the frame table,
// predicts every result from its own copy of the two-queue state and compares
// depends on tqpr_pkg
module tqpr_checker #(
  parameter int unsigned FRAMES   = 16,
  parameter int unsigned PIN_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIN_MAX  = (1 << PIN_BITS) - 1;
  localparam logic [1:0]  ADDR_FIU = 2'd0;

  // last field sits in the lowest bits, as on out_tdata
  typedef struct packed {
    logic [4:0]          resident;
    logic                wb;
    logic [63:0]         ev_id;
    logic                ev;
    logic                load;
    logic [3:0]          frame;
    tqpr_pkg::status_t   status;
  } page_result_t;

  page_result_t expected_results[$];

  logic [4:0]  frames_limit_reg;
  logic [63:0] tag       [FRAMES];
  logic        valid     [FRAMES];
  logic        in_lru    [FRAMES];
  int unsigned pin       [FRAMES];
  logic        dirty     [FRAMES];
  int unsigned rank      [FRAMES];
  int unsigned resident;

  function automatic void queue_leave(int f);
    for (int i = 0; i < FRAMES; i++)
      if (i != f && valid[i] && in_lru[i] == in_lru[f] && rank[i] > rank[f]) rank[i]--;
  endfunction

  function automatic void queue_join(int f, logic lru);
    for (int i = 0; i < FRAMES; i++)
      if (i != f && valid[i] && in_lru[i] == lru) rank[i]++;
    in_lru[f] = lru;
    rank[f]   = 0;
  endfunction

  function automatic int oldest_unpinned(logic lru);
    int best;
    best = -1;
    for (int i = 0; i < FRAMES; i++)
      if (valid[i] && in_lru[i] == lru && pin[i] == 0)
        if (best < 0 || rank[i] > rank[best]) best = i;
    return best;
  endfunction

  function automatic page_result_t predict_page_request(logic act, logic [63:0] id,
                                                       logic mark);
    page_result_t r;
    int f, slot;
    int unsigned limit;
    logic lru;
    r = '0;
    r.status = tqpr_pkg::ST_HIT;
    f = -1;
    for (int i = FRAMES - 1; i >= 0; i--)
      if (valid[i] && tag[i] == id) f = i;
    limit = frames_limit_reg;
    if (limit < 1) limit = 1;
    if (limit > FRAMES) limit = FRAMES;
    if (act == tqpr_pkg::ACT_UNFIX) begin
      if (f < 0 || pin[f] == 0) begin
        r.status = tqpr_pkg::ST_BAD_UNFIX;
      end else begin
        pin[f]--;
        if (mark) dirty[f] = 1'b1;
        r.frame = f[3:0];
      end
    end else if (f >= 0) begin
      if (pin[f] < PIN_MAX) pin[f]++;
      queue_leave(f);
      queue_join(f, 1'b1);
      r.frame = f[3:0];
    end else begin
      slot = -1;
      lru  = 1'b0;
      if (resident < limit) begin
        for (int i = FRAMES - 1; i >= 0; i--)
          if (!valid[i]) slot = i;
        if (slot >= 0) begin
          r.status = tqpr_pkg::ST_FREE;
          resident++;
        end
      end
      if (slot < 0) begin
        slot = oldest_unpinned(1'b0);
        if (slot < 0) begin
          slot = oldest_unpinned(1'b1);
          lru  = 1'b1;
        end
        if (slot >= 0) begin
          r.status = tqpr_pkg::ST_EVICT;
          r.ev     = 1'b1;
          r.ev_id  = tag[slot];
          r.wb     = dirty[slot];
          queue_leave(slot);
        end
      end
      if (slot < 0) begin
        r.status = tqpr_pkg::ST_FULL;
      end else begin
        valid[slot] = 1'b1;
        tag[slot]   = id;
        pin[slot]   = 1;
        dirty[slot] = 1'b0;
        queue_join(slot, lru);
        r.frame = slot[3:0];
        r.load  = 1'b1;
      end
    end
    r.resident = resident[4:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    page_result_t exp_r, got;
    if (!rst_n) begin
      frames_limit_reg <= 5'd16;
      for (int i = 0; i < FRAMES; i++) begin
        valid[i] = 1'b0; in_lru[i] = 1'b0; pin[i] = 0; dirty[i] = 1'b0; rank[i] = 0;
        tag[i] = '0;
      end
      resident = 0;
      expected_results.delete();
      errors <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_FIU)
        frames_limit_reg <= cfg_pwdata[4:0];
      if (in_tvalid && in_tready)
        expected_results.insert(expected_results.size(),
                                predict_page_request(in_tdata[0], in_tdata[64:1],
                                                     in_tdata[65]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[78:0];
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting: %h", $realtime, got);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            $display("%0t: result mismatch expected st=%0d fr=%0d ld=%b ev=%b id=%h wb=%b rc=%0d",
                     $realtime, exp_r.status, exp_r.frame, exp_r.load, exp_r.ev,
                     exp_r.ev_id, exp_r.wb, exp_r.resident);
            $display("%0t:                   actual st=%0d fr=%0d ld=%b ev=%b id=%h wb=%b rc=%0d",
                     $realtime, got.status, got.frame, got.load, got.ev, got.ev_id,
                     got.wb, got.resident);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// testbench: stimulus and verdict for the two-queue page replacement frame table
// depends on tqpr_pkg, two_queue_page_replacement and tqpr_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 20;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [87:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          errors, pending;

  // flags shared between the sender and the receiver process, and sender state
  logic        quiet_tail;   // no idling on either side
  logic        hold_req;     // receiver holds off for a long stretch
  logic [63:0] page_pool [POOL];
  int          requests_sent;

  two_queue_page_replacement i_dut (.*);

  tqpr_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous fixed limit for the whole run
  initial begin
    #3ms;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // one request: hold valid until accepted; valid stays high into the next request unless a random gap drops it
  task automatic send_page_request(logic act, logic [63:0] id, logic mark);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, mark, id, act};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    requests_sent++;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // every request answers, so an empty store means the block is idle
  task automatic wait_all_results();
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_frames_limit(logic [31:0] value);
    in_tvalid   <= 1'b0;
    wait_all_results();
    repeat (20) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 2'd0;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly pool pages so that hits, pins and evictions interact
  function automatic logic [63:0] pick_page();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return page_pool[$urandom_range(0, POOL - 1)];
  endfunction

  task automatic random_requests(int count);
    logic act;
    for (int n = 0; n < count; n++) begin
      act = ($urandom_range(0, 99) < 52) ? tqpr_pkg::ACT_FIX : tqpr_pkg::ACT_UNFIX;
      send_page_request(act, pick_page(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [31:0] limits [6];
    limits = '{32'd1, 32'd3, 32'd31, 32'd0, 32'd8, 32'd16};
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    quiet_tail = 1'b0; hold_req = 1'b0; requests_sent = 0;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL; i++) page_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset limit of 16, free loads, hit, unfix clean and dirty, bad unfixes
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[0], 1'b0);  // not resident
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[0], 1'b0);
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[1], 1'b1);
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[0], 1'b0);    // hit moves to lru
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[0], 1'b1);
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[0], 1'b0);
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[0], 1'b0);  // pin already zero
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[1], 1'b1);

    // one frame: limit below residency evicts from fifo, then lru, then full
    write_frames_limit(32'd1);
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[3], 1'b0);    // dirty fifo victim
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[3], 1'b0);
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[3], 1'b1);
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[3], 1'b0);
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[4], 1'b0);    // dirty lru victim
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[5], 1'b0);    // dirty lru victim
    send_page_request(tqpr_pkg::ACT_FIX, page_pool[6], 1'b0);    // everything pinned
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[4], 1'b0);
    send_page_request(tqpr_pkg::ACT_UNFIX, page_pool[5], 1'b0);

    // sender pauses until every result is back
    in_tvalid <= 1'b0;
    wait_all_results();
    repeat (5) @(posedge clk);

    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    random_requests(10);

    foreach (limits[k]) begin
      write_frames_limit(limits[k]);
      random_requests(55);
    end

    quiet_tail = 1'b1;
    random_requests(40);
    in_tvalid <= 1'b0;

    wait_all_results();
    repeat (40) @(posedge clk);
    $display("covered %0d requests: fix, unfix, hits, free loads, fifo and lru evictions,",
             requests_sent);
    $display("buffer full and bad unfix, long output stall, limits 0, 1, 3, 8, 16 and 31");
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/tqpr_pkg.sv
hw/rtl/tqpr_cell.sv
hw/rtl/two_queue_page_replacement.sv
hw/rtl/tqpr_checker.sv
tb/tqpr_checker.sv
tb/testbench.sv
